// File: sv/tgt_pkg.sv
// ============================================================================
// tgt_pkg: torus grid tessellator shared definitions
// Widths, stage counts, request and register codes, pipeline payload
// structs, the sine table and the fixed point rounding helpers.
// ============================================================================
`default_nettype none

package tgt_pkg;

    localparam int GRID_BITS      = 8;
    localparam int TABLE_BITS     = 8;
    localparam int TABLE_DEPTH    = 1 << TABLE_BITS;
    localparam int QUARTER_TURN   = TABLE_DEPTH / 4;
    localparam int FRAC_BITS      = 12;
    localparam int RADIUS_BITS    = 15;
    localparam int COORD_BITS     = 16;
    localparam int INDEX_BITS     = 16;
    localparam int SIN_BITS       = FRAC_BITS + 2;
    localparam int QUO_BITS       = TABLE_BITS + 2;
    localparam int DEN_BITS       = GRID_BITS + 1;
    localparam int NUM_BITS       = GRID_BITS + QUO_BITS;
    localparam int DIV_STEPS      = 2;
    localparam int DIV_STAGES     = QUO_BITS / DIV_STEPS;
    localparam int VTX_STAGES     = 4;
    localparam int VTX_FIRST      = 1 + DIV_STAGES;
    localparam int OUT_STAGE      = VTX_FIRST + VTX_STAGES;
    localparam int TUBE_PROD_BITS = RADIUS_BITS + 1 + SIN_BITS;
    localparam int RING_BITS      = RADIUS_BITS + 3;
    localparam int RING_PROD_BITS = RING_BITS + SIN_BITS;
    localparam int WIDE_BITS      = 40;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    localparam logic signed [WIDE_BITS-1:0] ROUND_HALF = WIDE_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [WIDE_BITS-1:0] COORD_MAX  = (WIDE_BITS'(1) << (COORD_BITS - 1)) - 1;
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN  = -(WIDE_BITS'(1) << (COORD_BITS - 1));

    localparam logic [GRID_BITS-1:0]   RESET_GRID_COLS   = GRID_BITS'(16);
    localparam logic [GRID_BITS-1:0]   RESET_GRID_ROWS   = GRID_BITS'(16);
    localparam logic [RADIUS_BITS-1:0] RESET_RING_RADIUS = RADIUS_BITS'(8192);
    localparam logic [RADIUS_BITS-1:0] RESET_TUBE_RADIUS = RADIUS_BITS'(4096);

    typedef enum logic [0:0] {
        REQ_VERTEX = 1'b0,
        REQ_FACE   = 1'b1
    } req_kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRID_COLS   = 3'd0,
        CFG_GRID_ROWS   = 3'd1,
        CFG_RING_RADIUS = 3'd2,
        CFG_TUBE_RADIUS = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_BITS-1:0]   rem;
        logic [NUM_BITS-1:0]   den_sh;
        logic [TABLE_BITS-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t col_lane;
        div_lane_t row_lane;
    } div_pair_t;

    typedef struct packed {
        logic                  bad;
        logic                  kind;
        logic [GRID_BITS-1:0]  col0;
        logic [GRID_BITS-1:0]  col1;
        logic [INDEX_BITS-1:0] row0;
        logic [INDEX_BITS-1:0] row1;
    } side_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic [INDEX_BITS-1:0]        tri0_a;
        logic [INDEX_BITS-1:0]        tri0_b;
        logic [INDEX_BITS-1:0]        tri0_c;
        logic [INDEX_BITS-1:0]        tri1_a;
        logic [INDEX_BITS-1:0]        tri1_b;
        logic [INDEX_BITS-1:0]        tri1_c;
        logic                         bad_request;
    } result_t;

    typedef logic [TABLE_DEPTH-1:0][SIN_BITS-1:0] sin_table_t;

    // sin(u * pi/2) in Q30 by Taylor series, u in Q30 on [0, 1]
    function automatic logic [63:0] quarter_sin(input logic [63:0] u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (u * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 2; n <= 12; n += 2) begin
            term = ((term * x2) >> 30) / 64'(n * (n + 1));
            if ((n % 4) == 2)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    function automatic logic [SIN_BITS-1:0] wave_entry(input logic [31:0] t);
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] m;
        r = {34'd0, t[29:0]};
        s = t[30] ? quarter_sin(ONE_Q30 - r) : quarter_sin(r);
        m = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (m > (64'd1 << FRAC_BITS))
            m = 64'd1 << FRAC_BITS;
        return t[31] ? SIN_BITS'(-m) : SIN_BITS'(m);
    endfunction

    function automatic sin_table_t build_sin_table();
        sin_table_t tab;
        for (int k = 0; k < TABLE_DEPTH; k++)
            tab[k] = wave_entry(32'(k) << (32 - TABLE_BITS));
        return tab;
    endfunction

    localparam sin_table_t SIN_TABLE = build_sin_table();

    // floor((v + half) / 2^FRAC_BITS)
    function automatic logic signed [WIDE_BITS-1:0] round_frac(
        input logic signed [WIDE_BITS-1:0] v
    );
        return (v + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        if (v > COORD_MAX)
            return COORD_MAX[COORD_BITS-1:0];
        if (v < COORD_MIN)
            return COORD_MIN[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/tgt_ifs.sv
// ============================================================================
// tgt_ifs: torus grid tessellator channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ============================================================================
`default_nettype none

interface tgt_req_if
    import tgt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [0:0]           req_type;
    logic [GRID_BITS-1:0] col;
    logic [GRID_BITS-1:0] row;

    modport source (output valid, req_type, col, row, input ready);
    modport sink   (input valid, req_type, col, row, output ready);
endinterface

interface tgt_res_if
    import tgt_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [INDEX_BITS-1:0]        tri0_a;
    logic [INDEX_BITS-1:0]        tri0_b;
    logic [INDEX_BITS-1:0]        tri0_c;
    logic [INDEX_BITS-1:0]        tri1_a;
    logic [INDEX_BITS-1:0]        tri1_b;
    logic [INDEX_BITS-1:0]        tri1_c;
    logic                         bad_request;

    modport source (
        output valid, coord_x, coord_y, coord_z,
               tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c, bad_request,
        input  ready
    );
    modport sink (
        input  valid, coord_x, coord_y, coord_z,
               tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c, bad_request,
        output ready
    );
endinterface

interface tgt_cfg_if
    import tgt_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/tgt_front.sv
// ============================================================================
// tgt_front: request decode stage
// Range check, divider operand setup and face row offsets, registered.
// ============================================================================
`default_nettype none

module tgt_front
    import tgt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [0:0]           kind,
    input  wire logic [GRID_BITS-1:0] col,
    input  wire logic [GRID_BITS-1:0] row,
    input  wire logic [GRID_BITS-1:0] grid_cols,
    input  wire logic [GRID_BITS-1:0] grid_rows,
    output div_pair_t                 div_out,
    output side_t                     side_out
);

    logic [GRID_BITS:0]          col_inc;
    logic [GRID_BITS:0]          row_inc;
    logic [GRID_BITS-1:0]        col1;
    logic [GRID_BITS-1:0]        row1;
    logic [DEN_BITS-1:0]         pitch;
    logic [DEN_BITS+GRID_BITS-1:0] row0_full;
    logic [DEN_BITS+GRID_BITS-1:0] row1_full;
    logic                        zero_grid;
    logic                        vtx_bad;
    logic                        face_bad;
    div_pair_t                   div_next;
    side_t                       side_next;
    div_pair_t                   div_reg;
    side_t                       side_reg;

    always_comb
    begin
        col_inc   = {1'b0, col} + 1'b1;
        row_inc   = {1'b0, row} + 1'b1;
        col1      = (col_inc == {1'b0, grid_cols}) ? '0 : col_inc[GRID_BITS-1:0];
        row1      = (row_inc == {1'b0, grid_rows}) ? '0 : row_inc[GRID_BITS-1:0];
        pitch     = {1'b0, grid_cols} + 1'b1;
        row0_full = pitch * row;
        row1_full = pitch * row1;
        zero_grid = (grid_cols == '0) || (grid_rows == '0);
        vtx_bad   = (col > grid_cols) || (row > grid_rows);
        face_bad  = (col >= grid_cols) || (row >= grid_rows);

        div_next.col_lane.rem    = {col, QUO_BITS'(0)} + NUM_BITS'(grid_cols);
        div_next.col_lane.den_sh = NUM_BITS'({grid_cols, 1'b0}) << (QUO_BITS - 1);
        div_next.col_lane.quo    = '0;
        div_next.row_lane.rem    = {row, QUO_BITS'(0)} + NUM_BITS'(grid_rows);
        div_next.row_lane.den_sh = NUM_BITS'({grid_rows, 1'b0}) << (QUO_BITS - 1);
        div_next.row_lane.quo    = '0;

        side_next.bad  = zero_grid || ((kind == REQ_FACE) ? face_bad : vtx_bad);
        side_next.kind = kind;
        side_next.col0 = col;
        side_next.col1 = col1;
        side_next.row0 = INDEX_BITS'(row0_full);
        side_next.row1 = INDEX_BITS'(row1_full);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

    assign div_out  = div_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// File: sv/tgt_div_stage.sv
// ============================================================================
// tgt_div_stage: angle divider stage
// Two restoring quotient steps for both the column and the row angle.
// ============================================================================
`default_nettype none

module tgt_div_stage
    import tgt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire div_pair_t d_in,
    output div_pair_t      d_out
);

    div_pair_t d_next;
    div_pair_t d_reg;

    function automatic div_lane_t div_step(input div_lane_t lane);
        div_lane_t res;
        res = lane;
        if (lane.rem >= lane.den_sh)
        begin
            res.rem = lane.rem - lane.den_sh;
            res.quo = {lane.quo[TABLE_BITS-2:0], 1'b1};
        end
        else
        begin
            res.quo = {lane.quo[TABLE_BITS-2:0], 1'b0};
        end
        res.den_sh = lane.den_sh >> 1;
        return res;
    endfunction

    always_comb
    begin
        d_next = d_in;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            d_next.col_lane = div_step(d_next.col_lane);
            d_next.row_lane = div_step(d_next.row_lane);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

// File: sv/tgt_vertex_pipe.sv
// ============================================================================
// tgt_vertex_pipe: torus point arithmetic
// Table lookup, tube products, ring term and ring products in four stages.
// ============================================================================
`default_nettype none

module tgt_vertex_pipe
    import tgt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [VTX_STAGES-1:0]  en,
    input  wire logic [TABLE_BITS-1:0]  idx_col,
    input  wire logic [TABLE_BITS-1:0]  idx_row,
    input  wire logic [RADIUS_BITS-1:0] ring_radius,
    input  wire logic [RADIUS_BITS-1:0] tube_radius,
    output logic signed [COORD_BITS-1:0]     coord_x,
    output logic signed [RING_PROD_BITS-1:0] prod_y,
    output logic signed [RING_PROD_BITS-1:0] prod_z
);

    logic [TABLE_BITS-1:0]           cos_col_idx;
    logic [TABLE_BITS-1:0]           cos_row_idx;
    logic signed [SIN_BITS-1:0]      sin_a_reg;
    logic signed [SIN_BITS-1:0]      cos_a_reg;
    logic signed [SIN_BITS-1:0]      sin_b1_reg;
    logic signed [SIN_BITS-1:0]      cos_b1_reg;
    logic signed [TUBE_PROD_BITS-1:0] px_reg;
    logic signed [TUBE_PROD_BITS-1:0] ps_reg;
    logic signed [SIN_BITS-1:0]      sin_b2_reg;
    logic signed [SIN_BITS-1:0]      cos_b2_reg;
    logic signed [COORD_BITS-1:0]    x3_reg;
    logic signed [RING_BITS-1:0]     ww_reg;
    logic signed [SIN_BITS-1:0]      sin_b3_reg;
    logic signed [SIN_BITS-1:0]      cos_b3_reg;
    logic signed [COORD_BITS-1:0]    x4_reg;
    logic signed [RING_PROD_BITS-1:0] py_reg;
    logic signed [RING_PROD_BITS-1:0] pz_reg;
    logic signed [TUBE_PROD_BITS-1:0] px_next;
    logic signed [TUBE_PROD_BITS-1:0] ps_next;
    logic signed [WIDE_BITS-1:0]     ww_wide;
    logic signed [COORD_BITS-1:0]    x3_next;
    logic signed [RING_BITS-1:0]     ww_next;
    logic signed [RING_PROD_BITS-1:0] py_next;
    logic signed [RING_PROD_BITS-1:0] pz_next;

    always_comb
    begin
        cos_col_idx = idx_col + TABLE_BITS'(QUARTER_TURN);
        cos_row_idx = idx_row + TABLE_BITS'(QUARTER_TURN);
        px_next = $signed({1'b0, tube_radius}) * cos_a_reg;
        ps_next = $signed({1'b0, tube_radius}) * sin_a_reg;
        x3_next = sat_coord(round_frac(WIDE_BITS'(px_reg)));
        ww_wide = round_frac(WIDE_BITS'(ps_reg))
                + $signed({{(WIDE_BITS - RADIUS_BITS){1'b0}}, ring_radius});
        ww_next = ww_wide[RING_BITS-1:0];
        py_next = ww_reg * sin_b3_reg;
        pz_next = ww_reg * cos_b3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sin_a_reg  <= $signed(SIN_TABLE[idx_col]);
            cos_a_reg  <= $signed(SIN_TABLE[cos_col_idx]);
            sin_b1_reg <= $signed(SIN_TABLE[idx_row]);
            cos_b1_reg <= $signed(SIN_TABLE[cos_row_idx]);
        end
        if (en[1])
        begin
            px_reg     <= px_next;
            ps_reg     <= ps_next;
            sin_b2_reg <= sin_b1_reg;
            cos_b2_reg <= cos_b1_reg;
        end
        if (en[2])
        begin
            x3_reg     <= x3_next;
            ww_reg     <= ww_next;
            sin_b3_reg <= sin_b2_reg;
            cos_b3_reg <= cos_b2_reg;
        end
        if (en[3])
        begin
            x4_reg <= x3_reg;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    assign coord_x = x4_reg;
    assign prod_y  = py_reg;
    assign prod_z  = pz_reg;

endmodule

`default_nettype wire

// File: sv/torus_grid_tessellator_core.sv
// ============================================================================
// torus_grid_tessellator_core: torus mesh point and face generator
// Turns grid requests into torus vertices or quad triangle indices.
// ============================================================================
// Channels: req takes a request (req_type, col, row); res returns exactly one
// result per request, in order; cfg writes grid_cols, grid_rows, ring_radius
// and tube_radius by index and is always ready. Write cfg only while idle.
// Throughput: one request per cycle when no stall intervenes. The pipeline
// has eleven register stages: decode, five angle divider stages (two
// quotient bits each), four vertex arithmetic stages (lookup, tube multiply,
// ring add, ring multiply) and the output register.
// Stall: each stage advances when it is empty or the stage above advances,
// so bubbles close up and req stays ready until every stage holds a request.
// Reset: all stages empty, registers return to 16, 16, 8192 and 4096.
// No table or memory needs clearing after reset.
// ============================================================================
`default_nettype none

module torus_grid_tessellator_core
    import tgt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tgt_req_if.sink   req,
    tgt_res_if.source res,
    tgt_cfg_if.sink   cfg
);

    logic [GRID_BITS-1:0]   grid_cols_reg;
    logic [GRID_BITS-1:0]   grid_rows_reg;
    logic [RADIUS_BITS-1:0] ring_radius_reg;
    logic [RADIUS_BITS-1:0] tube_radius_reg;

    logic [OUT_STAGE:0] valid_reg;
    logic [OUT_STAGE:0] valid_next;
    logic [OUT_STAGE:0] en;

    div_pair_t div_pipe [DIV_STAGES+1];
    side_t     front_side;
    side_t     side_reg [1:OUT_STAGE-1];

    logic signed [COORD_BITS-1:0]     vtx_x;
    logic signed [RING_PROD_BITS-1:0] vtx_py;
    logic signed [RING_PROD_BITS-1:0] vtx_pz;

    result_t result_reg;
    result_t result_next;
    side_t   last_side;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg   <= RESET_GRID_COLS;
            grid_rows_reg   <= RESET_GRID_ROWS;
            ring_radius_reg <= RESET_RING_RADIUS;
            tube_radius_reg <= RESET_TUBE_RADIUS;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_GRID_COLS:   grid_cols_reg   <= cfg.data[GRID_BITS-1:0];
                CFG_GRID_ROWS:   grid_rows_reg   <= cfg.data[GRID_BITS-1:0];
                CFG_RING_RADIUS: ring_radius_reg <= cfg.data[RADIUS_BITS-1:0];
                CFG_TUBE_RADIUS: tube_radius_reg <= cfg.data[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage advance chain
    assign en[OUT_STAGE] = !valid_reg[OUT_STAGE] || res.ready;

    for (genvar k = 0; k < OUT_STAGE; k++)
    begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    assign req.ready = en[0];

    always_comb
    begin
        valid_next[0] = en[0] ? req.valid : valid_reg[0];
        for (int k = 1; k <= OUT_STAGE; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // datapath
    tgt_front u_front (
        .clk       (clk),
        .en        (en[0]),
        .kind      (req.req_type),
        .col       (req.col),
        .row       (req.row),
        .grid_cols (grid_cols_reg),
        .grid_rows (grid_rows_reg),
        .div_out   (div_pipe[0]),
        .side_out  (front_side)
    );

    for (genvar d = 0; d < DIV_STAGES; d++)
    begin : g_div
        tgt_div_stage u_div (
            .clk   (clk),
            .en    (en[d+1]),
            .d_in  (div_pipe[d]),
            .d_out (div_pipe[d+1])
        );
    end

    tgt_vertex_pipe u_vertex (
        .clk         (clk),
        .en          (en[VTX_FIRST +: VTX_STAGES]),
        .idx_col     (div_pipe[DIV_STAGES].col_lane.quo),
        .idx_row     (div_pipe[DIV_STAGES].row_lane.quo),
        .ring_radius (ring_radius_reg),
        .tube_radius (tube_radius_reg),
        .coord_x     (vtx_x),
        .prod_y      (vtx_py),
        .prod_z      (vtx_pz)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
            side_reg[1] <= front_side;
        for (int k = 2; k < OUT_STAGE; k++)
        begin
            if (en[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    // result assembly
    assign last_side = side_reg[OUT_STAGE-1];

    always_comb
    begin
        result_next = '0;
        if (last_side.bad)
        begin
            result_next.bad_request = 1'b1;
        end
        else if (last_side.kind == REQ_VERTEX)
        begin
            result_next.coord_x = vtx_x;
            result_next.coord_y = sat_coord(round_frac(WIDE_BITS'(vtx_py)));
            result_next.coord_z = sat_coord(round_frac(WIDE_BITS'(vtx_pz)));
        end
        else
        begin
            result_next.tri0_a = last_side.row1 + INDEX_BITS'(last_side.col0);
            result_next.tri0_b = last_side.row1 + INDEX_BITS'(last_side.col1);
            result_next.tri0_c = last_side.row0 + INDEX_BITS'(last_side.col1);
            result_next.tri1_a = last_side.row0 + INDEX_BITS'(last_side.col1);
            result_next.tri1_b = last_side.row0 + INDEX_BITS'(last_side.col0);
            result_next.tri1_c = last_side.row1 + INDEX_BITS'(last_side.col0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
            result_reg <= result_next;
    end

    assign res.valid       = valid_reg[OUT_STAGE];
    assign res.coord_x     = result_reg.coord_x;
    assign res.coord_y     = result_reg.coord_y;
    assign res.coord_z     = result_reg.coord_z;
    assign res.tri0_a      = result_reg.tri0_a;
    assign res.tri0_b      = result_reg.tri0_b;
    assign res.tri0_c      = result_reg.tri0_c;
    assign res.tri1_a      = result_reg.tri1_a;
    assign res.tri1_b      = result_reg.tri1_b;
    assign res.tri1_c      = result_reg.tri1_c;
    assign res.bad_request = result_reg.bad_request;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.bad_request |->
            res.coord_x == '0 && res.coord_y == '0 && res.coord_z == '0 &&
            res.tri0_a == '0 && res.tri0_b == '0 && res.tri0_c == '0 &&
            res.tri1_a == '0 && res.tri1_b == '0 && res.tri1_c == '0)
        else $error("bad request result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.coord_x != '0 || res.coord_y != '0 || res.coord_z != '0) |->
            res.tri0_a == '0 && res.tri0_b == '0 && res.tri0_c == '0 &&
            res.tri1_a == '0 && res.tri1_b == '0 && res.tri1_c == '0)
        else $error("vertex result carries triangle indices");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[OUT_STAGE] && !res.ready && valid_reg[OUT_STAGE-1] |=>
            valid_reg[OUT_STAGE] && valid_reg[OUT_STAGE-1])
        else $error("stalled request lost from the last stages");

endmodule

`default_nettype wire
